[hdl/bndf_pkg.sv]
// ----------------------------------------------------------------------------
// bndf_pkg
// Widths, reset values and register indexes for the binary neighbor density
// filter.
// ----------------------------------------------------------------------------
package bndf_pkg;

  localparam int PIXEL_W       = 8;
  localparam int ROW_W         = 12;
  localparam int WIDTH_W       = 12;
  localparam int HEIGHT_W      = 13;
  localparam int DENSITY_W     = 4;
  localparam int NBR_COUNT_W   = 4;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;

  localparam logic [WIDTH_W-1:0]   WIDTH_RST   = 12'd640;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = 13'd480;
  localparam logic [DENSITY_W-1:0] DENSITY_RST = 4'd4;
  localparam logic [PIXEL_W-1:0]   FG_RST      = 8'd255;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DENSITY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_VALUE     = 2'd3;

endpackage

[hdl/bndf_pix_if.sv]
// ----------------------------------------------------------------------------
// bndf_pix_if
// Mask pixel channel: valid, ready and one pixel.
// ----------------------------------------------------------------------------
interface bndf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bndf_pkg::PIXEL_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

[hdl/bndf_res_if.sv]
// ----------------------------------------------------------------------------
// bndf_res_if
// Filtered pixel channel: value, position and end-of-frame flag.
// ----------------------------------------------------------------------------
interface bndf_res_if #(
  parameter int COL_W = 11
);
  logic                          valid;
  logic                          ready;
  logic [bndf_pkg::PIXEL_W-1:0]  pixel_out;
  logic [bndf_pkg::ROW_W-1:0]    out_row;
  logic [COL_W-1:0]              out_col;
  logic                          frame_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

[hdl/bndf_cfg_if.sv]
// ----------------------------------------------------------------------------
// bndf_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface bndf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bndf_pkg::CFG_IDX_W-1:0]   index;
  logic [bndf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/binary_neighbor_density_filter.sv]
// ----------------------------------------------------------------------------
// binary_neighbor_density_filter
// 3x3 neighbor-count filter on a streamed binary mask, two line stores and a
// sliding window; one result per interior pixel, one row and column behind.
//
//   channel    role    payload
//   pixels     sink    pixel_in
//   filtered   source  pixel_out, out_row, out_col, frame_last
//   cfg        sink    index, data (always ready)
//
// One pixel per clock while pixels.ready is high; a result sits in the output
// register the cycle after its pixel is taken.
// The line store read is registered and runs one position ahead, with a
// bypass from the write of the same cycle.
// After reset the line stores are cleared, every address in turn, with pixels
// held off; register writes are taken meanwhile.
// pixels.ready drops only while clearing, or while a result waits and filtered.ready is low.
// ----------------------------------------------------------------------------
module binary_neighbor_density_filter #(
  parameter int MAX_WIDTH = bndf_pkg::MAX_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bndf_pix_if.sink     pixels,
  bndf_res_if.source   filtered,
  bndf_cfg_if.sink     cfg
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = COL_W + 1;
  localparam int ROW_W = bndf_pkg::ROW_W;

  // registers
  logic [bndf_pkg::WIDTH_W-1:0]   image_width;
  logic [bndf_pkg::HEIGHT_W-1:0]  image_height;
  logic [bndf_pkg::DENSITY_W-1:0] min_density;
  logic [bndf_pkg::PIXEL_W-1:0]   fg_value;

  // line stores: bit 1 middle row, bit 0 upper row
  logic [1:0]       line_store [MAX_WIDTH];
  logic [1:0]       rd_bits;
  logic [5:0]       window_bits;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic             clearing;
  logic [COL_W-1:0] clr_addr;

  logic [CNT_W-1:0] eff_w;
  logic [ROW_W:0]   eff_h;
  logic [CNT_W-1:0] col_inc;
  logic [ROW_W:0]   row_inc;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             acc;
  logic             lower;
  logic [8:0]       win;
  logic [bndf_pkg::NBR_COUNT_W-1:0] nbr_count;
  logic             hit;
  logic             pass;
  logic             last_px;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [1:0]       wr_data;
  logic [COL_W-1:0] rd_addr;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bndf_pkg::WIDTH_RST;
      image_height <= bndf_pkg::HEIGHT_RST;
      min_density  <= bndf_pkg::DENSITY_RST;
      fg_value     <= bndf_pkg::FG_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bndf_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg.data[bndf_pkg::WIDTH_W-1:0];
        bndf_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg.data[bndf_pkg::HEIGHT_W-1:0];
        bndf_pkg::CFG_MIN_DENSITY:  min_density  <= cfg.data[bndf_pkg::DENSITY_W-1:0];
        bndf_pkg::CFG_FG_VALUE:     fg_value     <= cfg.data[bndf_pkg::PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (image_width > MAX_WIDTH) eff_w = CNT_W'(MAX_WIDTH);
    else                         eff_w = CNT_W'(image_width);
    if (eff_w == '0) eff_w = CNT_W'(1);
    if (image_height > bndf_pkg::MAX_HEIGHT) eff_h = (ROW_W+1)'(bndf_pkg::MAX_HEIGHT);
    else                                     eff_h = image_height;
    if (eff_h == '0) eff_h = (ROW_W+1)'(1);
  end

  assign pixels.ready = !clearing && (!filtered.valid || filtered.ready);
  assign acc          = pixels.valid && pixels.ready;

  // window and decision
  assign lower = (pixels.pixel_in == fg_value);
  assign win   = {window_bits, lower, rd_bits[1], rd_bits[0]};

  always_comb begin
    logic [7:0] nbr;
    nbr = {win[8:5], win[3:0]};
    nbr_count = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_count = nbr_count + bndf_pkg::NBR_COUNT_W'(nbr[i]);
    end
  end

  assign col_inc = {1'b0, col_count} + CNT_W'(1);
  assign row_inc = {1'b0, row_count} + (ROW_W+1)'(1);
  assign hit     = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2)) &&
                   ({1'b0, row_count} < eff_h) && ({1'b0, col_count} < eff_w);
  assign pass    = win[4] && (nbr_count >= min_density);
  assign last_px = (row_inc == eff_h) && (col_inc == eff_w);

  always_comb begin
    col_next = col_inc[COL_W-1:0];
    row_next = row_count;
    if (col_inc >= eff_w) begin
      col_next = '0;
      if (row_inc >= eff_h) row_next = '0;
      else                  row_next = row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      col_count   <= '0;
      window_bits <= '0;
    end else if (acc) begin
      row_count   <= row_next;
      col_count   <= col_next;
      window_bits <= win[5:0];
    end
  end

  // line store: clear sweep after reset, then one write per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) clearing <= 1'b0;
    end
  end

  assign wr_en   = clearing || acc;
  assign wr_addr = clearing ? clr_addr : col_count;
  assign wr_data = clearing ? 2'b00 : {lower, rd_bits[1]};
  assign rd_addr = acc ? col_next : col_count;

  always_ff @(posedge clk) begin
    if (wr_en) line_store[wr_addr] <= wr_data;
    if (wr_en && (wr_addr == rd_addr)) rd_bits <= wr_data;
    else                               rd_bits <= line_store[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered.valid <= 1'b0;
    end else if (acc) begin
      filtered.valid <= hit;
    end else if (filtered.ready) begin
      filtered.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      filtered.pixel_out  <= pass ? fg_value : '0;
      filtered.out_row    <= row_count - ROW_W'(1);
      filtered.out_col    <= col_count - COL_W'(1);
      filtered.frame_last <= last_px;
    end
  end

  // checks
  a_hold_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pixels.ready)
    else $error("pixel taken during line store clear");

  a_result_follows_hit: assert property (@(posedge clk) disable iff (rst)
    (acc && hit) |=> filtered.valid)
    else $error("interior pixel gave no result");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && last_px) |=> (row_count == '0) && (col_count == '0))
    else $error("position did not return to origin after last pixel");

  a_col_in_store: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col_count} < CNT_W'(MAX_WIDTH))
    else $error("column beyond line store depth");

endmodule
